>>> rtl/utf8_codepoint_decoder_assert.svh
// Assertion macros used by the decoder's back end.
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

// A property that must hold in the same cycle whenever the antecedent holds.
`define UTF8D_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8d: assertion failed");

// A property that must hold in the cycle after the antecedent holds.
`define UTF8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8d: assertion failed");

`endif

>>> rtl/utf8d_pkg.sv
`default_nettype none
package utf8d_pkg;

  // Default queue depths.
  localparam int IN_DEPTH_DEF  = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam int CP_W  = 21;
  localparam int CNT_W = 3;

  // One line byte together with its class.
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] len;   // sequence length if this byte leads
    logic       cont;  // 10xxxxxx
  } slot_t;

  typedef slot_t [3:0] win_t;

  // Beat held in the input queue.
  typedef struct packed {
    slot_t slot;
    logic  eol;
  } in_item_t;

  // Beat held in the result queue.
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
    logic             line_done;
    logic             last_of_run;
  } res_t;

  // Outcome of one decode step on the window.
  typedef struct packed {
    logic       emit;
    logic       hold;
    logic [2:0] used;
  } step_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    case (b) inside
      [8'h00:8'h7F]: n = 3'd1;
      [8'hC0:8'hDF]: n = 3'd2;
      [8'hE0:8'hEF]: n = 3'd3;
      [8'hF0:8'hF7]: n = 3'd4;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Decide what the first byte of a window of m bytes does.
  function automatic step_t classify(input win_t w, input logic [2:0] m, input logic eol);
    step_t      s;
    logic [2:0] n;
    logic [2:0] k;
    logic       broken;
    logic       fallback;
    n = w[0].len;
    k = (m < n) ? m : n;
    broken = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < k && !w[i].cont) broken = 1'b1;
    end
    fallback = (n == 3'd1) || broken || ((m < n) && eol);
    s.emit = fallback || (m >= n);
    s.hold = !fallback && (m < n);
    s.used = fallback ? 3'd1 : n;
    return s;
  endfunction

  // Build the code point from a complete sequence of n bytes.
  function automatic logic [CP_W-1:0] assemble(input win_t w, input logic [2:0] n);
    logic [CP_W-1:0] cp;
    case (n)
      3'd2:    cp = {10'd0, w[0].data[4:0], w[1].data[5:0]};
      3'd3:    cp = {5'd0, w[0].data[3:0], w[1].data[5:0], w[2].data[5:0]};
      3'd4:    cp = {w[0].data[2:0], w[1].data[5:0], w[2].data[5:0], w[3].data[5:0]};
      default: cp = {13'd0, w[0].data};
    endcase
    return cp;
  endfunction

endpackage
`default_nettype wire

>>> rtl/utf8_codepoint_decoder.sv
// Path: a byte accepted into the input queue is decoded by the engine, and its result is
// registered in the result queue, whose head drives the out_ ports until it is popped.
// Throughput: one byte per cycle while no run is in progress and the result queue has room;
// the engine emits one result per cycle while that queue has room, and a byte that completes
// several code points (at most four) starts a run, during which no new byte is taken.
// Reset: synchronous on rst_n low; both queues empty and no bytes held. No clearing pass.
`default_nettype none
module utf8_codepoint_decoder #(
  parameter int IN_DEPTH  = utf8d_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH = utf8d_pkg::OUT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_line,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [20:0]      out_code_point,
  output logic [2:0]       out_byte_count,
  output logic             out_line_done,
  output logic             out_last_of_run
);

  utf8d_pkg::in_item_t head;
  logic                head_valid, head_pop;
  logic                res_push, res_full;
  utf8d_pkg::res_t     res, res_q;

  // Front: classify and queue incoming bytes.
  utf8d_front #(
    .IN_DEPTH (IN_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data_byte   (in_data_byte),
    .in_end_of_line (in_end_of_line),
    .head_o         (head),
    .head_valid_o   (head_valid),
    .head_pop_i     (head_pop)
  );

  // Back: decode engine.
  utf8d_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .res_push_o   (res_push),
    .res_o        (res),
    .res_full_i   (res_full)
  );

  // Result queue toward the consumer.
  utf8d_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(utf8d_pkg::res_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_q),
    .empty (out_empty)
  );

  assign out_code_point  = res_q.code_point;
  assign out_byte_count  = res_q.byte_count;
  assign out_line_done   = res_q.line_done;
  assign out_last_of_run = res_q.last_of_run;

endmodule
`default_nettype wire

>>> rtl/utf8d_fifo.sv
`default_nettype none
module utf8d_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  // Status and head of the queue.
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

>>> rtl/utf8d_front.sv
`default_nettype none
module utf8d_front #(
  parameter int IN_DEPTH = utf8d_pkg::IN_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_end_of_line,
  output utf8d_pkg::in_item_t     head_o,
  output logic                    head_valid_o,
  input  wire logic               head_pop_i
);

  utf8d_pkg::in_item_t item;
  logic                q_empty;

  // Classify each byte as it arrives.
  always_comb begin
    item.slot.data = in_data_byte;
    item.slot.len  = utf8d_pkg::lead_length(in_data_byte);
    item.slot.cont = utf8d_pkg::is_cont(in_data_byte);
    item.eol       = in_end_of_line;
  end

  // Queue that decouples the input from the decode engine.
  utf8d_fifo #(
    .DEPTH (IN_DEPTH),
    .WIDTH ($bits(utf8d_pkg::in_item_t))
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (item),
    .full  (in_full),
    .pop   (head_pop_i),
    .dout  (head_o),
    .empty (q_empty)
  );

  assign head_valid_o = !q_empty;

endmodule
`default_nettype wire

>>> rtl/utf8d_back.sv
`default_nettype none
`include "utf8_codepoint_decoder_assert.svh"
module utf8d_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire utf8d_pkg::in_item_t head_i,
  input  wire logic                head_valid_i,
  output logic                     head_pop_o,
  output logic                     res_push_o,
  output utf8d_pkg::res_t          res_o,
  input  wire logic                res_full_i
);

  // Byte window: held bytes between beats, or the rest of a run in progress.
  utf8d_pkg::win_t win_r, win_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            eol_r, eol_nxt;
  logic            busy_r, busy_nxt;

  utf8d_pkg::win_t w, w2;
  utf8d_pkg::step_t st, nx;
  logic [2:0]      m, rem;
  logic [3:0]      src;
  logic            eol, have_work, go, finish;

  always_comb begin
    // Window for this step: the run in progress, or held bytes plus the new byte.
    for (int i = 0; i < 4; i++) begin
      if (busy_r || (3'(i) < cnt_r)) begin
        w[i] = win_r[i];
      end else if (3'(i) == cnt_r) begin
        w[i] = head_i.slot;
      end else begin
        w[i] = '0;
      end
    end
    m   = busy_r ? cnt_r : cnt_r + 3'd1;
    eol = busy_r ? eol_r : head_i.eol;
    st  = utf8d_pkg::classify(w, m, eol);

    // Drop the bytes that this step consumes.
    for (int i = 0; i < 4; i++) begin
      src = 4'(i) + {1'b0, st.used};
      if (!st.emit) begin
        w2[i] = w[i];
      end else if (src < 4'd4) begin
        w2[i] = w[src[1:0]];
      end else begin
        w2[i] = '0;
      end
    end
    rem = st.emit ? m - st.used : m;

    // Look ahead: the run ends when nothing is left or the rest must wait.
    nx     = utf8d_pkg::classify(w2, rem, eol);
    finish = !st.emit || (rem == 3'd0) || nx.hold;

    have_work  = busy_r || head_valid_i;
    go         = have_work && (!st.emit || !res_full_i);
    head_pop_o = go && !busy_r;
    res_push_o = go && st.emit;

    res_o.code_point  = utf8d_pkg::assemble(w, st.used);
    res_o.byte_count  = st.used;
    res_o.line_done   = eol && finish;
    res_o.last_of_run = finish;

    win_nxt  = win_r;
    cnt_nxt  = cnt_r;
    eol_nxt  = eol_r;
    busy_nxt = busy_r;
    if (go) begin
      win_nxt  = w2;
      cnt_nxt  = rem;
      eol_nxt  = eol;
      busy_nxt = !finish;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Window bytes are qualified by the count.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    eol_r <= eol_nxt;
  end

  // Between runs at most three bytes are held.
  `UTF8D_ASSERT(a_held_fits, clk, rst_n, !busy_r, cnt_r <= 3'd3)
  // A run in progress always has bytes left to decode.
  `UTF8D_ASSERT(a_busy_nonempty, clk, rst_n, busy_r, cnt_r != 3'd0)
  // A line never ends with bytes held.
  `UTF8D_ASSERT_NEXT(a_eol_clears, clk, rst_n, go && finish && eol, cnt_r == 3'd0 && !busy_r)

endmodule
`default_nettype wire
